// File: sv/w3f_pkg.sv
// shared types and constants of the 3x3 window filter
// no dependencies; imported by every module of the block but w3f_ram
package w3f_pkg;

	localparam int PIX_W        = 8;
	localparam int CFG_WIDTH_W  = 11;
	localparam int CFG_HEIGHT_W = 16;
	localparam int GEOM_COL_W   = 12;   // holds width minus one for the largest line length
	localparam int MAX_WIDTH_DEF = 1024;
	localparam int MIN_DIM      = 3;
	localparam int WINDOW_LAG   = 2;    // rows and columns that pass before a full window
	localparam int WIN_TAPS     = 6;    // two held columns of three pixels
	localparam int QUEUE_DEPTH  = 4;
	localparam int SUM_W        = 12;   // nine pixels summed
	localparam int DIFF_W       = 11;   // signed gradient
	localparam int RECIP_W      = 13;
	localparam logic [RECIP_W-1:0] RECIP_9 = 13'd7282;  // ceil(2^16 / 9)
	localparam int RECIP_SHIFT  = 16;

	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;
	localparam logic [APB_ADDR_W-1:0] ADDR_MODE   = 4'h0;
	localparam logic [APB_ADDR_W-1:0] ADDR_WIDTH  = 4'h4;
	localparam logic [APB_ADDR_W-1:0] ADDR_HEIGHT = 4'h8;

	// geometry seen by the front part
	typedef struct packed {
		logic [GEOM_COL_W-1:0]   width_m1;
		logic [CFG_HEIGHT_W-1:0] height_m1;
		logic                    restart;
	} geom_t;

	// one classified pixel, front to back
	typedef struct packed {
		logic [PIX_W-1:0] top;
		logic [PIX_W-1:0] mid;
		logic [PIX_W-1:0] bot;
		logic             produce;
		logic             last;
	} item_t;

endpackage

// File: sv/w3f_ram.sv
// generic single-clock ram, one write port and one registered read port
// no dependencies
module w3f_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: sv/w3f_front.sv
// front part: accepts pixels, tracks raster position, reads and updates line buffers
// depends on w3f_pkg and w3f_ram
module w3f_front
	import w3f_pkg::*;
#(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  geom_t            geom,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [PIX_W-1:0] in_pixel,
	input  logic             q_full,
	output logic             push,
	output item_t            push_item
);

	localparam int COL_W = $clog2(MAX_WIDTH);

	logic [COL_W-1:0]        col_q;
	logic [CFG_HEIGHT_W-1:0] row_q;
	logic                    valid_s1;
	logic [PIX_W-1:0]        pixel_s1;
	logic [COL_W-1:0]        addr_s1;
	logic                    produce_s1;
	logic                    last_s1;
	logic                    in_fire;
	logic                    col_last;
	logic                    row_last;
	logic [PIX_W-1:0]        upper_rd;
	logic [PIX_W-1:0]        middle_rd;

	assign col_last = (col_q == geom.width_m1[COL_W-1:0]);
	assign row_last = (row_q == geom.height_m1);
	assign push     = valid_s1 && !q_full;
	assign in_ready = !valid_s1 || !q_full;
	assign in_fire  = in_valid && in_ready;

	// raster position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (geom.restart) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_fire) begin
			if (col_last) begin
				col_q <= '0;
				row_q <= row_last ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			pixel_s1   <= in_pixel;
			addr_s1    <= col_q;
			produce_s1 <= (row_q >= CFG_HEIGHT_W'(WINDOW_LAG)) && (col_q >= COL_W'(WINDOW_LAG));
			last_s1    <= row_last && col_last;
		end
	end

	// line buffers: read on accept, written back when the item leaves
	w3f_ram #(
		.WIDTH(PIX_W),
		.DEPTH(MAX_WIDTH)
	) u_upper (
		.clk    (clk),
		.wr_en  (push),
		.wr_addr(addr_s1),
		.wr_data(middle_rd),
		.rd_en  (in_fire),
		.rd_addr(col_q),
		.rd_data(upper_rd)
	);

	w3f_ram #(
		.WIDTH(PIX_W),
		.DEPTH(MAX_WIDTH)
	) u_middle (
		.clk    (clk),
		.wr_en  (push),
		.wr_addr(addr_s1),
		.wr_data(pixel_s1),
		.rd_en  (in_fire),
		.rd_addr(col_q),
		.rd_data(middle_rd)
	);

	always_comb begin
		push_item.top     = upper_rd;
		push_item.mid     = middle_rd;
		push_item.bot     = pixel_s1;
		push_item.produce = produce_s1;
		push_item.last    = last_s1;
	end

`ifndef SYNTHESIS
	a_no_addr_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(push && in_fire) |-> (addr_s1 != col_q))
		else $error("line buffer read and write collide");
	a_col_bound: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= geom.width_m1[COL_W-1:0])
		else $error("column position beyond row length");
`endif

endmodule

// File: sv/w3f_queue.sv
// short fifo between the front and back parts
// depends on w3f_pkg
module w3f_queue
	import w3f_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	input  logic  pop,
	output logic  pop_valid,
	output item_t pop_item
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	item_t            entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_item  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count overflow");
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count lost a push");
`endif

endmodule

// File: sv/w3f_back.sv
// back part: 3x3 window columns, mean or vertical gradient, output register
// depends on w3f_pkg
module w3f_back
	import w3f_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             mode,
	input  logic             q_valid,
	input  item_t            q_item,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [PIX_W-1:0] out_value,
	output logic             out_last
);

	logic [PIX_W-1:0]         win_q [WIN_TAPS];
	logic                     valid_s1;
	logic [SUM_W-1:0]         sum_s1;
	logic signed [DIFF_W-1:0] diff_s1;
	logic                     mode_s1;
	logic                     last_s1;
	logic                     out_valid_q;
	logic [PIX_W-1:0]         out_value_q;
	logic                     out_last_q;
	logic                     out_free;
	logic                     s1_free;
	logic [SUM_W-1:0]         sum;
	logic [DIFF_W-1:0]        up_row;
	logic [DIFF_W-1:0]        dn_row;
	logic [SUM_W+RECIP_W-1:0] mean_prod;
	logic [PIX_W-1:0]         result;

	assign out_free = !out_valid_q || out_ready;
	assign s1_free  = !valid_s1 || out_free;
	assign pop      = q_valid && s1_free;

	// columns c-2 in taps 0..2, c-1 in taps 3..5, top/mid/bottom
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WIN_TAPS; i++) begin
				win_q[i] <= '0;
			end
		end else if (pop) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= q_item.top;
			win_q[4] <= q_item.mid;
			win_q[5] <= q_item.bot;
		end
	end

	always_comb begin
		sum = SUM_W'(win_q[0]) + SUM_W'(win_q[1]) + SUM_W'(win_q[2])
			+ SUM_W'(win_q[3]) + SUM_W'(win_q[4]) + SUM_W'(win_q[5])
			+ SUM_W'(q_item.top) + SUM_W'(q_item.mid) + SUM_W'(q_item.bot);
		up_row = DIFF_W'(win_q[0]) + DIFF_W'({win_q[3], 1'b0}) + DIFF_W'(q_item.top);
		dn_row = DIFF_W'(win_q[2]) + DIFF_W'({win_q[5], 1'b0}) + DIFF_W'(q_item.bot);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= pop && q_item.produce;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			sum_s1  <= sum;
			diff_s1 <= $signed(up_row - dn_row);
			mode_s1 <= mode;
			last_s1 <= q_item.last;
		end
	end

	// divide by nine through the reciprocal, clamp the gradient
	always_comb begin
		mean_prod = (SUM_W + RECIP_W)'(sum_s1) * (SUM_W + RECIP_W)'(RECIP_9);
		if (!mode_s1) begin
			result = mean_prod[RECIP_SHIFT +: PIX_W];
		end else if (diff_s1 < 0) begin
			result = '0;
		end else if (diff_s1 > $signed(DIFF_W'(255))) begin
			result = '1;
		end else begin
			result = diff_s1[PIX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s1) begin
			out_value_q <= result;
			out_last_q  <= last_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_value = out_value_q;
	assign out_last  = out_last_q;

endmodule

// File: sv/window_3x3_mean_or_sobel_filter_top.sv
// top level of the 3x3 window filter: apb registers and the three parts
// depends on w3f_pkg, w3f_front, w3f_queue, w3f_back
//
// usage
//   s_axis carries one 8-bit pixel per beat in raster order, row after row.
//   m_axis carries one result per interior pixel (borders give no beat);
//   tlast marks the last interior result of a frame.
//   the apb port holds filter_mode (0x0: 0 box mean, 1 vertical sobel),
//   image_width (0x4) and image_height (0x8); writing either geometry
//   register restarts the frame at row 0, column 0. write only while idle.
// timing
//   one pixel per clock sustained while m_axis_tready stays high; a result
//   leaves after the pixel that completes its window is accepted, through
//   the line buffer read, queue, arithmetic stage and output register. the
//   dual-port line buffers, one read and one write per cycle, set that rate.
// reset
//   arst_n clears position, window, queue and pipeline valids; mode 0,
//   width 8, height 8. line buffers are not cleared: rows 0 and 1 refill them.
// stalls
//   when m_axis_tready is low the result holds, the arithmetic stage and
//   the 4-entry queue fill, then s_axis_tready drops.
module window_3x3_mean_or_sobel_filter_top
	import w3f_pkg::*;
#(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// apb configuration
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	// pixel input
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [PIX_W-1:0]      s_axis_tdata,   // [7:0] pixel
	// filtered output
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [PIX_W-1:0]      m_axis_tdata,   // [7:0] filtered_value
	output logic                  m_axis_tlast    // frame_end
);

	localparam int WCLOG  = $clog2(MAX_WIDTH + 1);
	localparam int WCMP_W = (WCLOG > CFG_WIDTH_W) ? WCLOG : CFG_WIDTH_W;

	logic                    mode_q;
	logic [CFG_WIDTH_W-1:0]  width_q;
	logic [CFG_HEIGHT_W-1:0] height_q;
	logic                    cfg_wr;
	logic [WCMP_W-1:0]       width_ext;
	logic [WCMP_W-1:0]       width_m1;
	logic [CFG_HEIGHT_W-1:0] height_m1;
	geom_t                   geom;
	logic                    q_full;
	logic                    push;
	item_t                   push_item;
	logic                    pop;
	logic                    pop_valid;
	item_t                   pop_item;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= 1'b0;
			width_q  <= CFG_WIDTH_W'(8);
			height_q <= CFG_HEIGHT_W'(8);
		end else if (cfg_wr) begin
			unique case (paddr)
				ADDR_MODE:   mode_q   <= pwdata[0];
				ADDR_WIDTH:  width_q  <= pwdata[CFG_WIDTH_W-1:0];
				ADDR_HEIGHT: height_q <= pwdata[CFG_HEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr)
			ADDR_MODE:   prdata = APB_DATA_W'(mode_q);
			ADDR_WIDTH:  prdata = APB_DATA_W'(width_q);
			ADDR_HEIGHT: prdata = APB_DATA_W'(height_q);
			default:     prdata = '0;
		endcase
	end

	// effective geometry: width clamped to 3..MAX_WIDTH, height at least 3
	always_comb begin
		width_ext = WCMP_W'(width_q);
		if (width_ext < WCMP_W'(MIN_DIM)) begin
			width_m1 = WCMP_W'(MIN_DIM - 1);
		end else if (width_ext > WCMP_W'(MAX_WIDTH)) begin
			width_m1 = WCMP_W'(MAX_WIDTH - 1);
		end else begin
			width_m1 = width_ext - 1'b1;
		end
		if (height_q < CFG_HEIGHT_W'(MIN_DIM)) begin
			height_m1 = CFG_HEIGHT_W'(MIN_DIM - 1);
		end else begin
			height_m1 = height_q - 1'b1;
		end
		geom.width_m1  = GEOM_COL_W'(width_m1);
		geom.height_m1 = height_m1;
		geom.restart   = cfg_wr && ((paddr == ADDR_WIDTH) || (paddr == ADDR_HEIGHT));
	end

	w3f_front #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.geom     (geom),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_pixel (s_axis_tdata),
		.q_full   (q_full),
		.push     (push),
		.push_item(push_item)
	);

	w3f_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(push_item),
		.full     (q_full),
		.pop      (pop),
		.pop_valid(pop_valid),
		.pop_item (pop_item)
	);

	w3f_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.mode     (mode_q),
		.q_valid  (pop_valid),
		.q_item   (pop_item),
		.pop      (pop),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_value(m_axis_tdata),
		.out_last (m_axis_tlast)
	);

endmodule
